// ===== hw/rtl/vps_pkg.sv =====
// ----------------------------------------------------------------------------
// vps_pkg
// Shared types and constants of the vector proximal shrink unit.
// ----------------------------------------------------------------------------
package vps_pkg;

  localparam int NUM_LANES  = 8;
  localparam int GROUP_SIZE = 8;
  localparam int FRAC_BITS  = 8;
  localparam int ELEM_W     = 16;

  // squares, sums and root
  localparam int SQ_W       = 31;
  localparam int PAIR_W     = SQ_W + 1;
  localparam int SUM_W      = 34;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;

  // scale factor num/den and the lane divider
  localparam int NUM_W      = ROOT_W;
  localparam int PROD_W     = ELEM_W + NUM_W;
  localparam int QUO_W      = ELEM_W;

  // pipeline depths
  localparam int NORM_LAT   = 3 + ROOT_W;
  localparam int LANE_LAT   = 2 + QUO_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIDGE  = 2'd2;

  typedef enum logic [1:0] {
    MODE_SOFT    = 2'd0,
    MODE_GROUP   = 2'd1,
    MODE_RIDGE   = 2'd2,
    MODE_ELASTIC = 2'd3
  } mode_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][ELEM_W-1:0] elem;
    logic                             pass_through;
  } vec_t;

  typedef struct packed {
    logic             thr_en;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/vps_if.sv =====
// ----------------------------------------------------------------------------
// vps_in_if / vps_out_if
// Valid/ready channels for group vectors in and shrunk vectors out.
// ----------------------------------------------------------------------------
interface vps_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elem0;
  logic [15:0] elem1;
  logic [15:0] elem2;
  logic [15:0] elem3;
  logic [15:0] elem4;
  logic [15:0] elem5;
  logic [15:0] elem6;
  logic [15:0] elem7;
  logic        pass_through;

  modport source (output valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7,
                  pass_through, input ready);
  modport sink   (input valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7,
                  pass_through, output ready);
endinterface

interface vps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out0;
  logic [15:0] out1;
  logic [15:0] out2;
  logic [15:0] out3;
  logic [15:0] out4;
  logic [15:0] out5;
  logic [15:0] out6;
  logic [15:0] out7;

  modport source (output valid, out0, out1, out2, out3, out4, out5, out6, out7,
                  input ready);
  modport sink   (input valid, out0, out1, out2, out3, out4, out5, out6, out7,
                  output ready);
endinterface

// ===== hw/rtl/vps_norm.sv =====
// ----------------------------------------------------------------------------
// vps_norm
// Pipelined group L2 norm: squares, two-level sum, one root bit per stage.
// ----------------------------------------------------------------------------
module vps_norm
  import vps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  vec_t              in_vec,
  output logic              out_vld,
  output vec_t              out_vec,
  output logic [ROOT_W-1:0] norm
);

  logic [NUM_LANES-1:0][SQ_W-1:0]     sq;
  logic [NUM_LANES/2-1:0][PAIR_W-1:0] pair;
  logic [SUM_W-1:0]                   total;
  logic [2:0]                         pre_vld;
  vec_t [2:0]                         pre_vec;

  logic [ROOT_W-1:0]             vld;
  vec_t [ROOT_W-1:0]             vec;
  logic [ROOT_W-1:0][SUM_W-1:0]  sbits;
  logic [ROOT_W-1:0][REM_W-1:0]  rem;
  logic [ROOT_W-1:0][ROOT_W-1:0] root;

  // square, pair sum, total
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= '0;
    end else if (en) begin
      pre_vld <= {pre_vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_vec <= {pre_vec[1:0], in_vec};
      for (int i = 0; i < NUM_LANES; i++) begin
        sq[i] <= SQ_W'(32'($signed(in_vec.elem[i])) * 32'($signed(in_vec.elem[i])));
      end
      for (int i = 0; i < NUM_LANES / 2; i++) begin
        pair[i] <= PAIR_W'(sq[2*i]) + PAIR_W'(sq[2*i+1]);
      end
      total <= SUM_W'(pair[0]) + SUM_W'(pair[1]) + SUM_W'(pair[2]) + SUM_W'(pair[3]);
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic              p_vld;
    vec_t              p_vec;
    logic [SUM_W-1:0]  p_s;
    logic [REM_W-1:0]  p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [REM_W+1:0]  sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_vld  = pre_vld[2];
      assign p_vec  = pre_vec[2];
      assign p_s    = total;
      assign p_rem  = '0;
      assign p_root = '0;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_vec  = vec[k-1];
      assign p_s    = sbits[k-1];
      assign p_rem  = rem[k-1];
      assign p_root = root[k-1];
    end

    assign sh    = {p_rem, p_s[SUM_W-1 -: 2]};
    assign trial = {(REM_W-ROOT_W)'(0), p_root, 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec[k]   <= p_vec;
        sbits[k] <= {p_s[SUM_W-3:0], 2'b00};
        rem[k]   <= ge ? REM_W'(sh - trial) : REM_W'(sh);
        root[k]  <= {p_root[ROOT_W-2:0], ge};
      end
    end
  end

  assign out_vld = vld[ROOT_W-1];
  assign out_vec = vec[ROOT_W-1];
  assign norm    = root[ROOT_W-1];

endmodule

// ===== hw/rtl/vps_lane.sv =====
// ----------------------------------------------------------------------------
// vps_lane
// One element lane: optional soft threshold, then sign * floor(|v|*num/den)
// through a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vps_lane
  import vps_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ELEM_W-1:0] x,
  input  lane_ctrl_t        ctrl,
  input  logic [ELEM_W-1:0] thresh,
  output logic [ELEM_W-1:0] res
);

  logic signed [ELEM_W+1:0] xs;
  logic signed [ELEM_W+1:0] ts;
  logic signed [ELEM_W+1:0] v;
  logic signed [ELEM_W+1:0] mag_full;

  logic              s1_neg;
  logic [ELEM_W-1:0] s1_mag;
  logic [NUM_W-1:0]  s1_num;
  logic [NUM_W-1:0]  s1_den;

  logic              s2_neg;
  logic [PROD_W-1:0] s2_prod;
  logic [NUM_W-1:0]  s2_den;

  logic [QUO_W-1:0]             d_neg;
  logic [QUO_W-1:0][NUM_W-1:0]  d_den;
  logic [QUO_W-1:0][NUM_W-1:0]  d_rem;
  logic [QUO_W-1:0][QUO_W-1:0]  d_low;
  logic [QUO_W-1:0][QUO_W-1:0]  d_q;

  // soft threshold and magnitude
  always_comb begin
    xs = (ELEM_W+2)'($signed(x));
    ts = $signed({2'b00, thresh});
    v  = xs;
    if (ctrl.thr_en) begin
      if (xs > ts) begin
        v = xs - ts;
      end else if (xs < -ts) begin
        v = xs + ts;
      end else begin
        v = '0;
      end
    end
    mag_full = v[ELEM_W+1] ? -v : v;
  end

  // operand and product stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg  <= v[ELEM_W+1];
      s1_mag  <= mag_full[ELEM_W-1:0];
      s1_num  <= ctrl.num;
      s1_den  <= ctrl.den;
      s2_neg  <= s1_neg;
      s2_prod <= PROD_W'(s1_mag) * PROD_W'(s1_num);
      s2_den  <= s1_den;
    end
  end

  // restoring divider
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic              p_neg;
    logic [NUM_W-1:0]  p_den;
    logic [NUM_W-1:0]  p_rem;
    logic [QUO_W-1:0]  p_low;
    logic [QUO_W-1:0]  p_q;
    logic [NUM_W:0]    sh;
    logic              ge;

    if (k == 0) begin : g_first
      assign p_neg = s2_neg;
      assign p_den = s2_den;
      assign p_rem = s2_prod[PROD_W-1:QUO_W];
      assign p_low = s2_prod[QUO_W-1:0];
      assign p_q   = '0;
    end else begin : g_next
      assign p_neg = d_neg[k-1];
      assign p_den = d_den[k-1];
      assign p_rem = d_rem[k-1];
      assign p_low = d_low[k-1];
      assign p_q   = d_q[k-1];
    end

    assign sh = {p_rem, p_low[QUO_W-1]};
    assign ge = sh >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (en) begin
        d_neg[k] <= p_neg;
        d_den[k] <= p_den;
        d_rem[k] <= ge ? NUM_W'(sh - {1'b0, p_den}) : sh[NUM_W-1:0];
        d_low[k] <= {p_low[QUO_W-2:0], 1'b0};
        d_q[k]   <= {p_q[QUO_W-2:0], ge};
      end
    end
  end

  // restore sign
  assign res = d_neg[QUO_W-1] ? ELEM_W'(-d_q[QUO_W-1]) : d_q[QUO_W-1];

endmodule

// ===== hw/rtl/vector_proximal_shrink_unit.sv =====
// ----------------------------------------------------------------------------
// vector_proximal_shrink_unit
// Proximal shrinkage of one eight-element Q8.8 group vector per beat.
// ----------------------------------------------------------------------------
// The unit accepts one group vector every clock cycle while the output is not
// stalled, and each result passes through the norm pipeline with one root bit
// per stage, the lane pipeline with one quotient bit per divider stage and one
// output register. All stages advance together, so a stall at the output
// holds the whole pipeline and lowers ready at the input. Every mode runs
// through the same path, so latency does not depend on mode. Configuration
// must be written only while no beat is in flight.
module vector_proximal_shrink_unit
  import vps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vps_in_if.sink                vec_in,
  vps_out_if.source             vec_out
);

  mode_t             mode;
  logic [ELEM_W-1:0] shrink_threshold;
  logic [ELEM_W-1:0] ridge_lambda;

  logic              adv;
  vec_t              in_vec;
  logic              n_vld;
  vec_t              n_vec;
  logic [ROOT_W-1:0] n_norm;
  lane_ctrl_t        ctrl;
  logic [LANE_LAT-1:0]                  l_vld;
  logic [NUM_LANES-1:0][ELEM_W-1:0]     lane_res;
  logic [NUM_LANES-1:0][ELEM_W-1:0]     res;
  logic                                 res_vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_SOFT;
      shrink_threshold <= '0;
      ridge_lambda     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode             <= mode_t'(cfg_data[1:0]);
        REG_THRESH: shrink_threshold <= cfg_data;
        REG_RIDGE:  ridge_lambda     <= cfg_data;
        default:    ;
      endcase
    end
  end

  // whole pipeline moves when the output register is empty or being read
  assign adv          = !res_vld || vec_out.ready;
  assign vec_in.ready = adv;

  // input vector, lanes beyond the group read as zero
  always_comb begin
    in_vec.elem[0]      = vec_in.elem0;
    in_vec.elem[1]      = vec_in.elem1;
    in_vec.elem[2]      = vec_in.elem2;
    in_vec.elem[3]      = vec_in.elem3;
    in_vec.elem[4]      = vec_in.elem4;
    in_vec.elem[5]      = vec_in.elem5;
    in_vec.elem[6]      = vec_in.elem6;
    in_vec.elem[7]      = vec_in.elem7;
    in_vec.pass_through = vec_in.pass_through;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (i >= GROUP_SIZE) begin
        in_vec.elem[i] = '0;
      end
    end
  end

  vps_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (vec_in.valid),
    .in_vec  (in_vec),
    .out_vld (n_vld),
    .out_vec (n_vec),
    .norm    (n_norm)
  );

  // per-mode scale factor shared by all lanes
  always_comb begin
    ctrl.thr_en = 1'b0;
    ctrl.num    = NUM_W'(1);
    ctrl.den    = NUM_W'(1);
    if (!n_vec.pass_through) begin
      case (mode)
        MODE_SOFT: begin
          ctrl.thr_en = 1'b1;
        end
        MODE_GROUP: begin
          if (n_norm > NUM_W'(shrink_threshold)) begin
            ctrl.num = n_norm - NUM_W'(shrink_threshold);
            ctrl.den = n_norm;
          end else begin
            ctrl.num = '0;
          end
        end
        MODE_RIDGE: begin
          ctrl.num = NUM_W'(1) << FRAC_BITS;
          ctrl.den = (NUM_W'(1) << FRAC_BITS) + NUM_W'(ridge_lambda);
        end
        MODE_ELASTIC: begin
          ctrl.thr_en = 1'b1;
          ctrl.num    = NUM_W'(1) << FRAC_BITS;
          ctrl.den    = (NUM_W'(1) << FRAC_BITS) + NUM_W'(ridge_lambda);
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    vps_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .x      (n_vec.elem[i]),
      .ctrl   (ctrl),
      .thresh (shrink_threshold),
      .res    (lane_res[i])
    );
  end

  // lane valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld <= '0;
    end else if (adv) begin
      l_vld <= {l_vld[LANE_LAT-2:0], n_vld};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= l_vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= lane_res;
    end
  end

  assign vec_out.valid = res_vld;
  assign vec_out.out0  = res[0];
  assign vec_out.out1  = res[1];
  assign vec_out.out2  = res[2];
  assign vec_out.out3  = res[3];
  assign vec_out.out4  = res[4];
  assign vec_out.out5  = res[5];
  assign vec_out.out6  = res[6];
  assign vec_out.out7  = res[7];

  // divider never sees a zero divisor on a live beat
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    n_vld |-> ctrl.den != '0)
    else $error("zero divisor reached the lanes");

  // lane scale factor never exceeds one, in every mode
  a_scale_le_one: assert property (@(posedge clk) disable iff (rst)
    n_vld |-> ctrl.num <= ctrl.den)
    else $error("lane scale factor above one");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vec_out.valid)
    else $error("output valid after reset");

endmodule

// ===== tb/sv/tb_vps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vps_checker
// Watches the vector channels of the shrink unit, predicts each shrunk
// vector from the accepted input beat and the current register values, and
// compares every output beat lane by lane in order.
// ----------------------------------------------------------------------------
module tb_vps_checker
  import vps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vps_in_if                     vec_in,
  vps_out_if                    vec_out,
  output int                    fail_count,
  output int                    pending_count
);

  typedef logic [NUM_LANES-1:0][ELEM_W-1:0] lanes_t;

  mode_t       cur_mode;
  logic [15:0] cur_thresh;
  logic [15:0] cur_ridge;
  lanes_t      shrunk_q[$];

  assign pending_count = shrunk_q.size();

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic lanes_t shrink_vector(lanes_t in_v, logic pt);
    longint x[NUM_LANES];
    longint y;
    longint t;
    longint nrm;
    longint den;
    longint unsigned ssq;
    lanes_t res;
    t   = longint'(cur_thresh);
    den = (longint'(1) << FRAC_BITS) + longint'(cur_ridge);
    ssq = 0;
    res = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      x[i] = (i < GROUP_SIZE) ? longint'($signed(in_v[i])) : 0;
      ssq += longint'(x[i] * x[i]);
    end
    nrm = longint'(floor_sqrt(ssq));
    for (int i = 0; i < GROUP_SIZE; i++) begin
      y = x[i];
      if (pt) begin
        y = x[i];
      end else if (cur_mode == MODE_GROUP) begin
        y = (nrm > t) ? (x[i] * (nrm - t)) / nrm : 0;
      end else begin
        if (cur_mode == MODE_SOFT || cur_mode == MODE_ELASTIC)
          y = (y > t) ? y - t : ((y < -t) ? y + t : 0);
        if (cur_mode == MODE_RIDGE || cur_mode == MODE_ELASTIC)
          y = (y * (longint'(1) << FRAC_BITS)) / den;
      end
      res[i] = y[15:0];
    end
    return res;
  endfunction

  // register shadow, prediction and compare
  always @(posedge clk) begin
    lanes_t got;
    lanes_t exp_v;
    int     errs;
    errs = 0;
    if (rst) begin
      cur_mode   <= MODE_SOFT;
      cur_thresh <= '0;
      cur_ridge  <= '0;
      fail_count <= 0;
      shrunk_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   cur_mode   <= mode_t'(cfg_data[1:0]);
          REG_THRESH: cur_thresh <= cfg_data;
          REG_RIDGE:  cur_ridge  <= cfg_data;
          default: ;
        endcase
      end
      if (vec_in.valid && vec_in.ready)
        shrunk_q.push_back(shrink_vector({vec_in.elem7, vec_in.elem6, vec_in.elem5,
                                          vec_in.elem4, vec_in.elem3, vec_in.elem2,
                                          vec_in.elem1, vec_in.elem0},
                                         vec_in.pass_through));
      if (vec_out.valid && vec_out.ready) begin
        got = {vec_out.out7, vec_out.out6, vec_out.out5, vec_out.out4,
               vec_out.out3, vec_out.out2, vec_out.out1, vec_out.out0};
        if (shrunk_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
          errs++;
        end else begin
          exp_v = shrunk_q.pop_front();
          for (int i = 0; i < NUM_LANES; i++)
            if (got[i] !== exp_v[i]) begin
              $display("%0t: out%0d expected %h actual %h", $time, i, exp_v[i], got[i]);
              errs++;
            end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== tb/sv/tb_vector_proximal_shrink_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_proximal_shrink_unit
// Drives group vectors through every shrink mode under directed and random
// register settings with random gaps and output stalls; the checker judges each output beat.
// ----------------------------------------------------------------------------
module tb_vector_proximal_shrink_unit;
  import vps_pkg::*;

  localparam int LATENCY = 39;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending_count;

  vps_in_if  vec_in();
  vps_out_if vec_out();

  vector_proximal_shrink_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .vec_in(vec_in.sink), .vec_out(vec_out.source)
  );

  tb_vps_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .vec_in(vec_in), .vec_out(vec_out),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output stalls, with quiet stretches
  always @(posedge clk) begin
    if (rst) vec_out.ready <= 1'b0;
    else if (($time / 4000) % 3 == 0) vec_out.ready <= 1'b1;
    else vec_out.ready <= gap_len() == 0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vec(logic [NUM_LANES-1:0][15:0] v, logic pt, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      vec_in.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vec_in.valid <= 1'b1;
    vec_in.pass_through <= pt;
    {vec_in.elem7, vec_in.elem6, vec_in.elem5, vec_in.elem4,
     vec_in.elem3, vec_in.elem2, vec_in.elem1, vec_in.elem0} <= v;
    @(posedge clk);
    while (!vec_in.ready) @(posedge clk);
  endtask

  task automatic end_burst();
    vec_in.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_burst(int n);
    logic [NUM_LANES-1:0][15:0] v;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < NUM_LANES; i++) v[i] = rand_elem();
      send_vec(v, $urandom_range(0, 9) == 0, 1'b1);
    end
    end_burst();
  endtask

  // stimulus
  initial begin
    logic [NUM_LANES-1:0][15:0] v;
    vec_in.valid = 1'b0;
    vec_in.pass_through = 1'b0;
    {vec_in.elem0, vec_in.elem1, vec_in.elem2, vec_in.elem3} = '0;
    {vec_in.elem4, vec_in.elem5, vec_in.elem6, vec_in.elem7} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero vector, pass-through in every mode
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 16'(m));
      write_reg(REG_THRESH, 16'h0180);
      write_reg(REG_RIDGE, 16'h0100);
      send_vec('0, 1'b0, 1'b0);
      send_vec({8{16'h8000}}, 1'b0, 1'b0);
      send_vec({8{16'h7fff}}, 1'b0, 1'b0);
      send_vec({16'h0100, 16'hff00, 16'h0180, 16'hfe80,
                16'h0001, 16'hffff, 16'h7fff, 16'h8000}, 1'b0, 1'b0);
      send_vec({16'h8000, 16'h7fff, 16'h1234, 16'hedcb,
                16'h0000, 16'h0001, 16'h5555, 16'haaaa}, 1'b1, 1'b0);
      end_burst();
      drain();
    end
    // unused register index and high data bits
    write_reg(2'd3, 16'hffff);
    write_reg(REG_MODE, 16'hfffd);

    // random phases over register settings, extremes first
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin write_reg(REG_THRESH, 16'h0000); write_reg(REG_RIDGE, 16'h0000); end
        1: begin write_reg(REG_THRESH, 16'hffff); write_reg(REG_RIDGE, 16'hffff); end
        default: begin
          write_reg(REG_THRESH, ($urandom_range(0, 1)) ? 16'($urandom_range(0, 1024))
                                                       : 16'($urandom));
          write_reg(REG_RIDGE, ($urandom_range(0, 1)) ? 16'($urandom_range(0, 1024))
                                                      : 16'($urandom));
        end
      endcase
      write_reg(REG_MODE, 16'(p % 4));
      rand_burst(40);
      drain();
    end

    // group mode around the norm boundary
    write_reg(REG_MODE, MODE_GROUP);
    write_reg(REG_THRESH, 16'h0200);
    v = '0;
    v[0] = 16'h0200;
    send_vec(v, 1'b0, 1'b0);
    v[0] = 16'h0201;
    send_vec(v, 1'b0, 1'b0);
    end_burst();
    drain();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vps_pkg.sv
hw/rtl/vps_if.sv
hw/rtl/vps_norm.sv
hw/rtl/vps_lane.sv
hw/rtl/vector_proximal_shrink_unit.sv
tb/sv/tb_vps_checker.sv
tb/sv/tb_vector_proximal_shrink_unit.sv
